/* rtl/pfan_pkg.sv */
// Shared types, widths and helpers for the polygon face area normal block.
// No dependencies; every rtl file references this package by scoped names.
package pfan_pkg;

  // Face bound and the number of coordinate bits that take part.
  // Coordinates carry 8 fraction bits; the normal carries 2*8 = 16.
  localparam int MAX_FACE_VERTICES = 64;
  localparam int COORD_BITS        = 24;

  // Field widths fixed by the interface.
  localparam int TAG_W   = 32;
  localparam int COORD_W = 24;
  localparam int NORM_W  = 56;
  localparam int COUNT_W = 7;

  // Datapath widths.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  // Queue depths.
  localparam int OP_DEPTH  = 4;
  localparam int OP_PTR_W  = $clog2(OP_DEPTH);
  localparam int OP_CNT_W  = OP_PTR_W + 1;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = RES_PTR_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord_vec_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } diff_vec_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] zy;
    logic signed [PROD_W-1:0] zx;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] yx;
  } prod_set_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } cross_vec_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } norm_vec_t;

  typedef struct packed {
    logic [TAG_W-1:0]          face_id;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic                      last_vertex;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]         face_label;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [COUNT_W-1:0]       vertex_count;
    logic                     too_many_vertices;
  } out_word_t;

  // Control that travels with each classified word.
  typedef struct packed {
    logic               add;
    logic               last;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } op_meta_t;

  // One classified word: meta plus the two cross product operands.
  typedef struct packed {
    op_meta_t  meta;
    diff_vec_t a;
    diff_vec_t b;
  } op_t;

  // Keep the low COORD_BITS bits and sign extend them to the field width.
  function automatic coord_t sext_coord(input logic [COORD_W-1:0] raw);
    logic signed [COORD_W-1:0] t;
    t = raw << (COORD_W - COORD_BITS);
    return t >>> (COORD_W - COORD_BITS);
  endfunction

  function automatic diff_vec_t vec_sub(input coord_vec_t p, input coord_vec_t q);
    diff_vec_t d;
    d.x = DIFF_W'(p.x) - DIFF_W'(q.x);
    d.y = DIFF_W'(p.y) - DIFF_W'(q.y);
    d.z = DIFF_W'(p.z) - DIFF_W'(q.z);
    return d;
  endfunction

endpackage

/* rtl/polygon_face_area_normal_top.sv */
// Polygon face area normal: one vertex word per cycle unless full, one result per face.
// Throughput: one word per cycle unless full, set by six multipliers and the accumulator.
// Path: a last vertex word passes the op queue, stage 1, stage 2, then the result queue.
// Reset: synchronous, active low rst_n; empties both queues, clears face state.
// Queues: four ops between front and back, four results before the output.
// Depends on pfan_pkg, pfan_front, pfan_op_queue and pfan_back.
module polygon_face_area_normal_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  pfan_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output pfan_pkg::out_word_t out_word
);

  // Front to queue: classified op for every accepted vertex word.
  logic          op_push;
  pfan_pkg::op_t op_word;
  // Queue to back.
  logic          op_full;
  logic          op_empty;
  logic          op_pop;
  pfan_pkg::op_t op_head;

  // The input side stalls only when the op queue is full; the back part
  // drains it on its own schedule, so a waiting result never blocks intake
  // until both queues have filled.
  assign full = op_full;

  // Classify: track first, newest even and newest odd corner, count and
  // overflow; emit the operands of at most one cross product per word.
  pfan_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_word (in_word),
    .q_full  (op_full),
    .op_push (op_push),
    .op_word (op_word)
  );

  // Decouple: hold classified ops while the back part is stalled.
  pfan_op_queue u_op_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_word (op_word),
    .pop       (op_pop),
    .full      (op_full),
    .empty     (op_empty),
    .head_word (op_head)
  );

  // Execute: multiply, form cross components, accumulate, and drop the
  // finished normal into the result queue on the last word of a face.
  pfan_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_empty (op_empty),
    .op_head  (op_head),
    .op_pop   (op_pop),
    .out_word (out_word),
    .empty    (empty),
    .pop      (pop)
  );

  // A cross product is only ever requested once three corners are known;
  // the triangle closing term is the earliest one.
  assert property (@(posedge clk) disable iff (!rst_n)
    op_push && op_word.meta.add |-> op_word.meta.count >= pfan_pkg::COUNT_W'(3))
    else $error("cross product requested before the third vertex");

  // Faces with fewer than three vertices must report a zero normal.
  assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_word.vertex_count < pfan_pkg::COUNT_W'(3)) |->
      out_word.normal_x == '0 && out_word.normal_y == '0 && out_word.normal_z == '0)
    else $error("short face with nonzero normal");

  // The overflow flag only appears with a saturated count.
  assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_word.too_many_vertices |->
      out_word.vertex_count == pfan_pkg::COUNT_W'(pfan_pkg::MAX_FACE_VERTICES))
    else $error("overflow flag without saturated vertex count");

endmodule

/* rtl/pfan_front.sv */
// Front part: tracks the face state and turns each vertex word into an op.
// Depends on pfan_pkg.
module pfan_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfan_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              op_push,
  output pfan_pkg::op_t     op_word
);

  logic [pfan_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;
  pfan_pkg::coord_vec_t         first_r, first_nxt;
  pfan_pkg::coord_vec_t         prev_r, prev_nxt;
  pfan_pkg::coord_vec_t         prev_odd_r, prev_odd_nxt;

  pfan_pkg::coord_vec_t         v;
  pfan_pkg::coord_vec_t         a_src;
  pfan_pkg::coord_vec_t         b_src;
  logic [pfan_pkg::COUNT_W-1:0] cnt_new;
  logic                         ovf_hit;
  logic                         is_first;
  logic                         odd;
  logic                         vert_add;
  logic                         close_add;

  assign op_push = push && !q_full;

  always_comb begin
    v.x = pfan_pkg::sext_coord(in_word.vertex_x);
    v.y = pfan_pkg::sext_coord(in_word.vertex_y);
    v.z = pfan_pkg::sext_coord(in_word.vertex_z);

    ovf_hit  = count_r >= pfan_pkg::COUNT_W'(pfan_pkg::MAX_FACE_VERTICES);
    is_first = count_r == '0;
    odd      = count_r[0];
    cnt_new  = ovf_hit ? count_r : count_r + pfan_pkg::COUNT_W'(1);

    vert_add  = !ovf_hit && odd && (count_r >= pfan_pkg::COUNT_W'(3));
    close_add = in_word.last_vertex && cnt_new[0] &&
                (cnt_new >= pfan_pkg::COUNT_W'(3));

    // An even vertex that is taken becomes the newest even corner.
    a_src = (!ovf_hit && !odd && !is_first) ? v : prev_r;
    b_src = close_add ? first_r : v;

    op_word.meta.add   = vert_add || close_add;
    op_word.meta.last  = in_word.last_vertex;
    op_word.meta.tag   = in_word.face_id;
    op_word.meta.count = cnt_new;
    op_word.meta.ovf   = ovf_r || ovf_hit;
    op_word.a          = pfan_pkg::vec_sub(a_src, first_r);
    op_word.b          = pfan_pkg::vec_sub(b_src, prev_odd_r);

    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    prev_odd_nxt = prev_odd_r;
    if (op_push) begin
      if (in_word.last_vertex) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = cnt_new;
        ovf_nxt   = ovf_r || ovf_hit;
        if (!ovf_hit) begin
          if (is_first) begin
            first_nxt = v;
            prev_nxt  = v;
          end else if (odd) begin
            prev_odd_nxt = v;
          end else begin
            prev_nxt = v;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
    first_r    <= first_nxt;
    prev_r     <= prev_nxt;
    prev_odd_r <= prev_odd_nxt;
  end

endmodule

/* rtl/pfan_op_queue.sv */
// Short queue of classified ops between the front and back parts.
// Depends on pfan_pkg.
module pfan_op_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfan_pkg::op_t push_word,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output pfan_pkg::op_t head_word
);

  pfan_pkg::op_t                 mem_r [pfan_pkg::OP_DEPTH];
  logic [pfan_pkg::OP_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pfan_pkg::OP_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pfan_pkg::OP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full      = cnt_r == pfan_pkg::OP_CNT_W'(pfan_pkg::OP_DEPTH);
  assign empty     = cnt_r == '0;
  assign head_word = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + pfan_pkg::OP_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + pfan_pkg::OP_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + pfan_pkg::OP_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - pfan_pkg::OP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

/* rtl/pfan_back.sv */
// Back part: cross product pipeline, normal accumulator and result queue.
// Depends on pfan_pkg.
module pfan_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_empty,
  input  pfan_pkg::op_t       op_head,
  output logic                op_pop,
  output pfan_pkg::out_word_t out_word,
  output logic                empty,
  input  logic                pop
);

  // Stage 1: six partial products.
  logic                 s1_v_r, s1_v_nxt;
  pfan_pkg::op_meta_t   s1_meta_r;
  pfan_pkg::prod_set_t  s1_prod_r;
  // Stage 2: cross product components.
  logic                 s2_v_r, s2_v_nxt;
  pfan_pkg::op_meta_t   s2_meta_r;
  pfan_pkg::cross_vec_t s2_cross_r, s2_cross_nxt;
  // Accumulator.
  pfan_pkg::norm_vec_t  sum_r, sum_nxt;
  pfan_pkg::norm_vec_t  acc;

  // Result queue.
  pfan_pkg::out_word_t            res_r [pfan_pkg::RES_DEPTH];
  logic [pfan_pkg::RES_PTR_W-1:0] res_wr_r, res_wr_nxt;
  logic [pfan_pkg::RES_PTR_W-1:0] res_rd_r, res_rd_nxt;
  logic [pfan_pkg::RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                           res_full;
  logic                           res_push;
  logic                           res_pop;
  pfan_pkg::out_word_t            res_word;

  logic en;

  assign res_full = res_cnt_r == pfan_pkg::RES_CNT_W'(pfan_pkg::RES_DEPTH);
  assign empty    = res_cnt_r == '0;
  assign out_word = res_r[res_rd_r];
  assign res_pop  = pop && !empty;

  // Stall the whole back pipeline while the result queue is full.
  assign en       = !res_full;
  assign op_pop   = en && !op_empty;
  assign res_push = en && s2_v_r && s2_meta_r.last;

  always_comb begin
    s1_v_nxt = en ? !op_empty : s1_v_r;
    s2_v_nxt = en ? s1_v_r : s2_v_r;

    if (s1_meta_r.add) begin
      s2_cross_nxt.x = pfan_pkg::CROSS_W'(s1_prod_r.yz) - pfan_pkg::CROSS_W'(s1_prod_r.zy);
      s2_cross_nxt.y = pfan_pkg::CROSS_W'(s1_prod_r.zx) - pfan_pkg::CROSS_W'(s1_prod_r.xz);
      s2_cross_nxt.z = pfan_pkg::CROSS_W'(s1_prod_r.xy) - pfan_pkg::CROSS_W'(s1_prod_r.yx);
    end else begin
      s2_cross_nxt = '0;
    end

    acc.x = sum_r.x + pfan_pkg::NORM_W'(s2_cross_r.x);
    acc.y = sum_r.y + pfan_pkg::NORM_W'(s2_cross_r.y);
    acc.z = sum_r.z + pfan_pkg::NORM_W'(s2_cross_r.z);

    sum_nxt = sum_r;
    if (en && s2_v_r) begin
      sum_nxt = s2_meta_r.last ? '0 : acc;
    end

    res_word.face_label        = s2_meta_r.tag;
    res_word.normal_x          = acc.x;
    res_word.normal_y          = acc.y;
    res_word.normal_z          = acc.z;
    res_word.vertex_count      = s2_meta_r.count;
    res_word.too_many_vertices = s2_meta_r.ovf;

    res_wr_nxt  = res_push ? res_wr_r + pfan_pkg::RES_PTR_W'(1) : res_wr_r;
    res_rd_nxt  = res_pop ? res_rd_r + pfan_pkg::RES_PTR_W'(1) : res_rd_r;
    res_cnt_nxt = res_cnt_r;
    if (res_push && !res_pop) begin
      res_cnt_nxt = res_cnt_r + pfan_pkg::RES_CNT_W'(1);
    end else if (res_pop && !res_push) begin
      res_cnt_nxt = res_cnt_r - pfan_pkg::RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      sum_r     <= '0;
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      sum_r     <= sum_nxt;
      res_wr_r  <= res_wr_nxt;
      res_rd_r  <= res_rd_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
    if (en) begin
      s1_meta_r    <= op_head.meta;
      s1_prod_r.yz <= pfan_pkg::PROD_W'(op_head.a.y) * pfan_pkg::PROD_W'(op_head.b.z);
      s1_prod_r.zy <= pfan_pkg::PROD_W'(op_head.a.z) * pfan_pkg::PROD_W'(op_head.b.y);
      s1_prod_r.zx <= pfan_pkg::PROD_W'(op_head.a.z) * pfan_pkg::PROD_W'(op_head.b.x);
      s1_prod_r.xz <= pfan_pkg::PROD_W'(op_head.a.x) * pfan_pkg::PROD_W'(op_head.b.z);
      s1_prod_r.xy <= pfan_pkg::PROD_W'(op_head.a.x) * pfan_pkg::PROD_W'(op_head.b.y);
      s1_prod_r.yx <= pfan_pkg::PROD_W'(op_head.a.y) * pfan_pkg::PROD_W'(op_head.b.x);
      s2_meta_r    <= s1_meta_r;
      s2_cross_r   <= s2_cross_nxt;
    end
    if (res_push) begin
      res_r[res_wr_r] <= res_word;
    end
  end

endmodule

/* tb/polygon_face_area_normal_top_tb.sv */
// Self-checking bench for polygon_face_area_normal_top: streams faces, predicts each normal.
// Depends on pfan_pkg (word types, widths, face bound) and the top level RTL.
`timescale 1ns / 100ps

module polygon_face_area_normal_top_tb;

  localparam int               LIMIT_CYCLES  = 200000;
  localparam int               IDLE_PCT      = 36;
  localparam int               RANDOM_WORDS  = 1900;
  localparam pfan_pkg::coord_t C_MIN         = 24'sh800000;
  localparam pfan_pkg::coord_t C_MAX         = 24'sh7FFFFF;
  localparam pfan_pkg::coord_t C_ZERO        = 24'sh000000;
  localparam pfan_pkg::coord_t C_ONE         = 24'sh000100;   // 1.0 with eight fraction bits

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  pfan_pkg::in_word_t  in_word = '0;
  logic                full;
  logic                empty;
  pfan_pkg::out_word_t out_word;

  // Vertex words waiting to be offered, and normals the block still owes us.
  pfan_pkg::in_word_t  vertex_stream[$];
  pfan_pkg::out_word_t pending_normals[$];

  int        errors = 0;
  int        cycle_count = 0;
  int        vertices_taken = 0;
  int        hold_left = 0;
  bit        held_once = 1'b0;
  logic      calm;

  // Running face state of the predictor.
  longint    face_first[3];
  longint    face_prev_odd[3];
  longint    face_prev[3];
  longint    normal_acc[3];
  int        face_seen = 0;
  bit        face_overflow = 1'b0;

  polygon_face_area_normal_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // Neither side idles while this window of the stream goes through.
  assign calm = (vertices_taken >= 700) && (vertices_taken < 1100);

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Accumulate cross(a, b) into the running normal.
  function automatic void add_cross(longint ax, longint ay, longint az,
                                    longint bx, longint by, longint bz);
    normal_acc[0] += ay * bz - az * by;
    normal_acc[1] += az * bx - ax * bz;
    normal_acc[2] += ax * by - ay * bx;
  endfunction

  function automatic void clear_face();
    for (int i = 0; i < 3; i++) begin
      face_first[i]    = 0;
      face_prev_odd[i] = 0;
      face_prev[i]     = 0;
      normal_acc[i]    = 0;
    end
    face_seen     = 0;
    face_overflow = 1'b0;
  endfunction

  // Fold one accepted vertex word into the face; on the last word, owe a normal.
  function automatic void absorb_vertex(pfan_pkg::in_word_t w);
    longint              v[3];
    pfan_pkg::out_word_t res;
    v[0] = longint'($signed(w.vertex_x));
    v[1] = longint'($signed(w.vertex_y));
    v[2] = longint'($signed(w.vertex_z));
    if (face_seen >= pfan_pkg::MAX_FACE_VERTICES) begin
      // Past the bound: drop the vertex, remember that it came.
      face_overflow = 1'b1;
    end else begin
      if (face_seen == 0) begin
        for (int i = 0; i < 3; i++) begin
          face_first[i] = v[i];
          face_prev[i]  = v[i];
        end
      end else if (face_seen % 2 == 1) begin
        // Odd index closes a diagonal pair once a full pair exists.
        if (face_seen >= 3)
          add_cross(face_prev[0] - face_first[0], face_prev[1] - face_first[1],
                    face_prev[2] - face_first[2], v[0] - face_prev_odd[0],
                    v[1] - face_prev_odd[1], v[2] - face_prev_odd[2]);
        for (int i = 0; i < 3; i++) face_prev_odd[i] = v[i];
      end else begin
        for (int i = 0; i < 3; i++) face_prev[i] = v[i];
      end
      face_seen++;
    end
    if (!w.last_vertex) return;
    // Odd count: close the polygon back to the first vertex.
    if (face_seen % 2 == 1 && face_seen >= 3)
      add_cross(face_prev[0] - face_first[0], face_prev[1] - face_first[1],
                face_prev[2] - face_first[2], face_first[0] - face_prev_odd[0],
                face_first[1] - face_prev_odd[1], face_first[2] - face_prev_odd[2]);
    res.face_label = w.face_id;
    if (face_seen >= 3) begin
      res.normal_x = pfan_pkg::NORM_W'(normal_acc[0]);
      res.normal_y = pfan_pkg::NORM_W'(normal_acc[1]);
      res.normal_z = pfan_pkg::NORM_W'(normal_acc[2]);
    end else begin
      // Point or segment: no area.
      res.normal_x = '0;
      res.normal_y = '0;
      res.normal_z = '0;
    end
    res.vertex_count      = pfan_pkg::COUNT_W'(face_seen);
    res.too_many_vertices = face_overflow;
    pending_normals.push_back(res);
    clear_face();
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  function automatic void queue_vertex(logic [pfan_pkg::TAG_W-1:0] id,
                                       pfan_pkg::coord_t x, pfan_pkg::coord_t y,
                                       pfan_pkg::coord_t z, logic last);
    pfan_pkg::in_word_t w;
    w.face_id     = id;
    w.vertex_x    = x;
    w.vertex_y    = y;
    w.vertex_z    = z;
    w.last_vertex = last;
    vertex_stream.push_back(w);
  endfunction

  // Mostly full-range coordinates, with extremes and small values mixed in.
  function automatic pfan_pkg::coord_t pick_coord();
    case ($urandom_range(0, 9))
      0:       return C_MIN;
      1:       return C_MAX;
      2, 3, 4: return pfan_pkg::coord_t'($signed($urandom_range(0, 2047)) - 1024);
      default: return pfan_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic void queue_face(int n);
    logic [pfan_pkg::TAG_W-1:0] id;
    id = $urandom;
    for (int i = 0; i < n; i++)
      queue_vertex(id, pick_coord(), pick_coord(), pick_coord(), i == n - 1);
  endfunction

  // ---------------------------------------------------------------------
  // Input side: offer the head word at the falling edge, retire it on accept
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (vertex_stream.size() != 0 &&
                 (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
      push    <= 1'b1;
      in_word <= vertex_stream[0];
    end else begin
      push <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      absorb_vertex(vertex_stream.pop_front());
      vertices_taken++;
    end
  end

  // ---------------------------------------------------------------------
  // Result side: random pop, one long hold-off to back the block up
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      // Hold pop low long enough that both internal queues fill and full rises.
      if (!held_once && vertices_taken >= 300) begin
        hold_left = 250;
        held_once = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare each popped word with the oldest normal owed.
  always @(posedge clk) begin : check_results
    pfan_pkg::out_word_t want;
    if (rst_n && pop && !empty) begin
      if (pending_normals.size() == 0) begin
        $error("result word with no face pending, face_label %h", out_word.face_label);
        errors++;
      end else begin
        want = pending_normals.pop_front();
        if (out_word.face_label !== want.face_label) begin
          $error("face_label expected %h actual %h", want.face_label, out_word.face_label);
          errors++;
        end
        if (out_word.normal_x !== want.normal_x) begin
          $error("normal_x expected %0d actual %0d", want.normal_x, out_word.normal_x);
          errors++;
        end
        if (out_word.normal_y !== want.normal_y) begin
          $error("normal_y expected %0d actual %0d", want.normal_y, out_word.normal_y);
          errors++;
        end
        if (out_word.normal_z !== want.normal_z) begin
          $error("normal_z expected %0d actual %0d", want.normal_z, out_word.normal_z);
          errors++;
        end
        if (out_word.vertex_count !== want.vertex_count) begin
          $error("vertex_count expected %0d actual %0d", want.vertex_count,
                 out_word.vertex_count);
          errors++;
        end
        if (out_word.too_many_vertices !== want.too_many_vertices) begin
          $error("too_many_vertices expected %0b actual %0b", want.too_many_vertices,
                 out_word.too_many_vertices);
          errors++;
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: build the whole stream, release reset, drain, decide
  // ---------------------------------------------------------------------

  initial begin : run
    int n;
    int built;
    clear_face();

    // Directed faces first.
    // Single vertex at the positive corner: no area.
    queue_vertex(32'h0000_0000, C_MAX, C_MAX, C_MAX, 1'b1);
    // Two vertices spanning the whole range: still no area.
    queue_vertex(32'hFFFF_FFFF, C_MIN, C_MIN, C_MIN, 1'b0);
    queue_vertex(32'hFFFF_FFFF, C_MAX, C_MAX, C_MAX, 1'b1);
    // Unit right triangle in the xy plane.
    queue_vertex(32'h0000_0003, C_ZERO, C_ZERO, C_ZERO, 1'b0);
    queue_vertex(32'h0000_0003, C_ONE, C_ZERO, C_ZERO, 1'b0);
    queue_vertex(32'h0000_0003, C_ZERO, C_ONE, C_ZERO, 1'b1);
    // Triangle on the extremes: largest diagonal products.
    queue_vertex(32'h8000_0000, C_MIN, C_MAX, C_ZERO, 1'b0);
    queue_vertex(32'h8000_0000, C_MAX, C_MIN, C_MAX, 1'b0);
    queue_vertex(32'h8000_0000, C_MIN, C_MIN, C_MAX, 1'b1);
    // Unit square, even count with no closing term.
    queue_vertex(32'h7FFF_FFFF, C_ZERO, C_ZERO, C_ONE, 1'b0);
    queue_vertex(32'h7FFF_FFFF, C_ONE, C_ZERO, C_ONE, 1'b0);
    queue_vertex(32'h7FFF_FFFF, C_ONE, C_ONE, C_ONE, 1'b0);
    queue_vertex(32'h7FFF_FFFF, C_ZERO, C_ONE, C_ONE, 1'b1);
    // Pentagon: odd count, closes back to the first vertex.
    queue_vertex(32'h0000_0005, C_ZERO, C_ZERO, C_ZERO, 1'b0);
    queue_vertex(32'h0000_0005, C_ONE, C_ZERO, C_MIN, 1'b0);
    queue_vertex(32'h0000_0005, C_ONE, C_ONE, C_MAX, 1'b0);
    queue_vertex(32'h0000_0005, C_ZERO, C_ONE, C_ZERO, 1'b0);
    queue_vertex(32'h0000_0005, C_MIN, C_MAX, C_ONE, 1'b1);
    // Hexagon alternating between the corners.
    for (int i = 0; i < 6; i++)
      queue_vertex(32'h5A5A_A5A5, (i % 2) ? C_MAX : C_MIN, (i % 3 == 0) ? C_MIN : C_MAX,
                   (i < 3) ? C_MAX : C_MIN, i == 5);

    // Random faces: one oversized face up front, then a mix of sizes.
    built = 0;
    while (built < RANDOM_WORDS) begin
      if (built == 0)
        n = pfan_pkg::MAX_FACE_VERTICES + 2;
      else case ($urandom_range(0, 99))
        0, 1, 2, 3:       n = $urandom_range(pfan_pkg::MAX_FACE_VERTICES - 4,
                                             pfan_pkg::MAX_FACE_VERTICES + 8);
        4, 5, 6, 7, 8, 9: n = $urandom_range(1, 2);
        default:          n = $urandom_range(3, 9);
      endcase
      queue_face(n);
      built += n;
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every word taken, every normal seen, then a quiet wait before the verdict.
    while (vertex_stream.size() != 0) @(negedge clk);
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
